// ===== rtl/core/fcbb_pkg.sv =====
// fcbb_pkg: shared constants, types and helpers for the frame change bounding box
// used by every module of the block; depends on nothing

package fcbb_pkg;

  // frame size limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // counter widths follow the size limits
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // fixed field widths
  localparam int PIX_W   = 32;
  localparam int SIZE_W  = 12;
  localparam int COORD_W = 11;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // register reset values
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  // register indexes
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  // last column and row index of a frame, taken from the size registers
  typedef struct packed {
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
  } size_cfg_t;

  // word handed from the input register to the tracker
  typedef struct packed {
    logic valid;
    logic changed;
  } front_word_t;

  // zero acts as one, oversize clamps to the limit; returns size minus one
  function automatic logic [COL_W-1:0] col_last_of(input logic [SIZE_W-1:0] raw);
    logic [COL_W-1:0] res;
    if (raw == '0) begin
      res = '0;
    end else if (int'(raw) > MAX_WIDTH) begin
      res = COL_W'(MAX_WIDTH - 1);
    end else begin
      res = COL_W'(raw - SIZE_W'(1));
    end
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] row_last_of(input logic [SIZE_W-1:0] raw);
    logic [ROW_W-1:0] res;
    if (raw == '0) begin
      res = '0;
    end else if (int'(raw) > MAX_HEIGHT) begin
      res = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      res = ROW_W'(raw - SIZE_W'(1));
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/fcbb_cfg.sv =====
// fcbb_cfg: APB-style register file for the frame width and height
// depends on fcbb_pkg

module fcbb_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcbb_pkg::ADDR_W-1:0]   paddr,
  input  logic [fcbb_pkg::DATA_W-1:0]   pwdata,
  output logic [fcbb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output fcbb_pkg::size_cfg_t           size_cfg
);

  logic [fcbb_pkg::SIZE_W-1:0] frame_width;
  logic [fcbb_pkg::SIZE_W-1:0] frame_height;
  fcbb_pkg::reg_index_t        reg_sel;
  logic                        wr_en;
  logic [fcbb_pkg::SIZE_W-1:0] wr_val;

  // word address decode
  assign reg_sel = fcbb_pkg::reg_index_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign wr_val  = pwdata[fcbb_pkg::SIZE_W-1:0];
  assign pready  = 1'b1;

  // raw registers plus precomputed last indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= fcbb_pkg::WIDTH_RESET;
      frame_height      <= fcbb_pkg::HEIGHT_RESET;
      size_cfg.col_last <= fcbb_pkg::col_last_of(fcbb_pkg::WIDTH_RESET);
      size_cfg.row_last <= fcbb_pkg::row_last_of(fcbb_pkg::HEIGHT_RESET);
    end else if (wr_en) begin
      unique case (reg_sel)
        fcbb_pkg::REG_WIDTH: begin
          frame_width       <= wr_val;
          size_cfg.col_last <= fcbb_pkg::col_last_of(wr_val);
        end
        fcbb_pkg::REG_HEIGHT: begin
          frame_height      <= wr_val;
          size_cfg.row_last <= fcbb_pkg::row_last_of(wr_val);
        end
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      fcbb_pkg::REG_WIDTH:  prdata = fcbb_pkg::DATA_W'(frame_width);
      fcbb_pkg::REG_HEIGHT: prdata = fcbb_pkg::DATA_W'(frame_height);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/fcbb_front.sv =====
// fcbb_front: input register, reduces each pixel pair to a changed flag
// depends on fcbb_pkg

module fcbb_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fcbb_pkg::PIX_W-1:0]  pixel_value,
  input  logic [fcbb_pkg::PIX_W-1:0]  reference_value,
  input  logic                        hold,
  output fcbb_pkg::front_word_t       front_word
);

  // hold comes from the tracker when the stored word cannot move on
  assign in_stall = hold;

  // valid flag under reset; changed flag: xor of the pair is nonzero
  always_ff @(posedge clk) begin
    if (rst) begin
      front_word.valid <= 1'b0;
    end else if (!hold) begin
      front_word.valid <= in_valid;
    end
    if (!hold && in_valid) begin
      front_word.changed <= |(pixel_value ^ reference_value);
    end
  end

endmodule

// ===== rtl/core/fcbb_track.sv =====
// fcbb_track: position counters, running min/max and the result register
// depends on fcbb_pkg

module fcbb_track (
  input  logic                          clk,
  input  logic                          rst,
  input  fcbb_pkg::front_word_t         front_word,
  input  fcbb_pkg::size_cfg_t           size_cfg,
  output logic                          hold,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fcbb_pkg::COORD_W-1:0]  box_left,
  output logic [fcbb_pkg::COORD_W-1:0]  box_top,
  output logic [fcbb_pkg::COORD_W-1:0]  box_right,
  output logic [fcbb_pkg::COORD_W-1:0]  box_bottom,
  output logic                          any_changed
);

  logic [fcbb_pkg::COL_W-1:0] column_count;
  logic [fcbb_pkg::ROW_W-1:0] row_count;
  logic [fcbb_pkg::COL_W-1:0] min_column;
  logic [fcbb_pkg::COL_W-1:0] max_column;
  logic [fcbb_pkg::ROW_W-1:0] min_row;
  logic [fcbb_pkg::ROW_W-1:0] max_row;
  logic                       seen_change;

  logic [fcbb_pkg::COL_W-1:0] min_column_next;
  logic [fcbb_pkg::COL_W-1:0] max_column_next;
  logic [fcbb_pkg::ROW_W-1:0] min_row_next;
  logic [fcbb_pkg::ROW_W-1:0] max_row_next;
  logic                       seen_change_next;

  logic row_end;
  logic frame_end;
  logic out_free;
  logic fire;

  // position of the word held in the input register
  assign row_end   = column_count >= size_cfg.col_last;
  assign frame_end = row_end && (row_count >= size_cfg.row_last);

  // result slot is empty or being emptied this cycle
  assign out_free = !out_valid || !out_stall;
  assign fire     = front_word.valid && (!frame_end || out_free);
  assign hold     = front_word.valid && !fire;

  // fold the current pixel into the box
  always_comb begin
    min_column_next  = min_column;
    max_column_next  = max_column;
    min_row_next     = min_row;
    max_row_next     = max_row;
    seen_change_next = seen_change;
    if (front_word.changed) begin
      seen_change_next = 1'b1;
      if (!seen_change || column_count < min_column) min_column_next = column_count;
      if (!seen_change || column_count > max_column) max_column_next = column_count;
      if (!seen_change || row_count < min_row)       min_row_next    = row_count;
      if (!seen_change || row_count > max_row)       max_row_next    = row_count;
    end
  end

  // counters and running box
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      min_column   <= '1;
      max_column   <= '0;
      min_row      <= '1;
      max_row      <= '0;
      seen_change  <= 1'b0;
    end else if (fire) begin
      if (frame_end) begin
        column_count <= '0;
        row_count    <= '0;
        min_column   <= '1;
        max_column   <= '0;
        min_row      <= '1;
        max_row      <= '0;
        seen_change  <= 1'b0;
      end else begin
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + fcbb_pkg::ROW_W'(1);
        end else begin
          column_count <= column_count + fcbb_pkg::COL_W'(1);
        end
        min_column  <= min_column_next;
        max_column  <= max_column_next;
        min_row     <= min_row_next;
        max_row     <= max_row_next;
        seen_change <= seen_change_next;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && frame_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, all zero when nothing changed
  always_ff @(posedge clk) begin
    if (fire && frame_end) begin
      any_changed <= seen_change_next;
      if (seen_change_next) begin
        box_left   <= fcbb_pkg::COORD_W'(min_column_next);
        box_top    <= fcbb_pkg::COORD_W'(min_row_next);
        box_right  <= fcbb_pkg::COORD_W'(max_column_next);
        box_bottom <= fcbb_pkg::COORD_W'(max_row_next);
      end else begin
        box_left   <= '0;
        box_top    <= '0;
        box_right  <= '0;
        box_bottom <= '0;
      end
    end
  end

  // running box stays ordered
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    seen_change |-> (min_column <= max_column) && (min_row <= max_row))
    else $error("running box min above max");

  // a frame end always loads the result register
  a_frame_end_loads: assert property (@(posedge clk) disable iff (rst)
    fire && frame_end |=> out_valid)
    else $error("frame end without result");

  // a frame end clears the tracking state
  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && frame_end |=> (column_count == '0) && (row_count == '0) && !seen_change)
    else $error("state not cleared after frame end");

  // an empty frame reports a zero box
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_changed |->
      (box_left == '0) && (box_top == '0) && (box_right == '0) && (box_bottom == '0))
    else $error("empty frame with nonzero box");

endmodule

// ===== rtl/core/frame_change_bounding_box.sv =====
// frame_change_bounding_box: top level, bounding box of changed pixels per frame
// depends on fcbb_pkg, fcbb_cfg, fcbb_front and fcbb_track
//
//   channel  direction  handshake            word
//   input    in         in_valid / in_stall  pixel_value, reference_value
//   output   out        out_valid/ out_stall box_left, box_top, box_right, box_bottom,
//                                            any_changed
//   config   in         APB psel/penable     frame_width @0x0, frame_height @0x4
//
// one pixel per clock while in_stall is low; a frame's result word is loaded into the
// result register when the tracker takes its last pixel from the input register
// the input register and the result register are the two pipeline stages
// a stalled result blocks only a frame's last pixel; other pixels keep flowing
// synchronous active-high reset restores the size registers to 640 x 480 and
// clears the counters and the running box

module frame_change_bounding_box (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fcbb_pkg::PIX_W-1:0]    pixel_value,
  input  logic [fcbb_pkg::PIX_W-1:0]    reference_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fcbb_pkg::COORD_W-1:0]  box_left,
  output logic [fcbb_pkg::COORD_W-1:0]  box_top,
  output logic [fcbb_pkg::COORD_W-1:0]  box_right,
  output logic [fcbb_pkg::COORD_W-1:0]  box_bottom,
  output logic                          any_changed,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcbb_pkg::ADDR_W-1:0]   paddr,
  input  logic [fcbb_pkg::DATA_W-1:0]   pwdata,
  output logic [fcbb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  fcbb_pkg::size_cfg_t   size_cfg;
  fcbb_pkg::front_word_t front_word;
  logic                  hold;

  // size registers
  fcbb_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .size_cfg (size_cfg)
  );

  // input register
  fcbb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .pixel_value     (pixel_value),
    .reference_value (reference_value),
    .hold            (hold),
    .front_word      (front_word)
  );

  // counters, box and result register
  fcbb_track u_track (
    .clk         (clk),
    .rst         (rst),
    .front_word  (front_word),
    .size_cfg    (size_cfg),
    .hold        (hold),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .box_left    (box_left),
    .box_top     (box_top),
    .box_right   (box_right),
    .box_bottom  (box_bottom),
    .any_changed (any_changed)
  );

endmodule
